/* hdl/linear_probe_hash_table_defines.svh */
// Assertion macros for the hash table top module.
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPHT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPHT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/lpht_pkg.sv */
package lpht_pkg;

	// Default number of slots in the table.
	localparam int TABLE_SIZE_DEF = 8;

	// Key width and the widths of the result fields.
	localparam int KEY_W = 32;
	localparam int KIND_W = 2;
	localparam int STATUS_W = 3;
	localparam int OUT_IDX_W = 3;

	// Request kinds.
	typedef enum logic [KIND_W-1:0] {
		K_INSERT = 2'd0,
		K_DELETE = 2'd1,
		K_SEARCH = 2'd2,
		K_NOP = 2'd3
	} kind_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		S_INSERTED = 3'd0,
		S_FULL = 3'd1,
		S_DELETED = 3'd2,
		S_NOT_FOUND = 3'd3,
		S_FOUND = 3'd4
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HOME,
		ST_PROBE,
		ST_RESULT
	} state_t;

	// One table entry: occupied flag and stored key.
	typedef struct packed {
		logic valid;
		logic [KEY_W-1:0] key;
	} entry_t;

	// Status of the home slot unit.
	typedef struct packed {
		logic busy;
		logic done;
	} mod_sts_t;

endpackage

/* hdl/lpht_mod.sv */
module lpht_mod #(
	parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF,
	parameter int IDX_W = $clog2(TABLE_SIZE)
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [lpht_pkg::KEY_W-1:0] key,
	output lpht_pkg::mod_sts_t sts,
	output logic [IDX_W-1:0] home
);
	import lpht_pkg::*;

	localparam bit IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
	// Scaled reciprocal of the table size; the quotient is exact for every key.
	localparam int SHIFT = KEY_W + IDX_W;
	localparam int HALF_W = 17;
	localparam int PROD_W = KEY_W + HALF_W;
	localparam int ACC_W = KEY_W + 2 * HALF_W;
	localparam logic [63:0] RECIP = ((64'd1 << SHIFT) / 64'(TABLE_SIZE)) + 64'd1;
	localparam logic [HALF_W-1:0] RECIP_LO = HALF_W'(RECIP);
	localparam logic [HALF_W-1:0] RECIP_HI = HALF_W'(RECIP >> HALF_W);
	localparam logic [HALF_W-1:0] SIZE_C = HALF_W'(TABLE_SIZE);

	// Steps of the shared multiplier.
	localparam logic [1:0] STEP_LO = 2'd0;
	localparam logic [1:0] STEP_HI = 2'd1;
	localparam logic [1:0] STEP_REM = 2'd2;

	logic busy_q;
	logic done_q;
	logic [1:0] step_q;
	logic [KEY_W-1:0] key_q;
	logic [ACC_W-1:0] acc_q;
	logic [IDX_W-1:0] rem_q;
	logic [KEY_W-1:0] quot;
	logic [KEY_W-1:0] mul_a;
	logic [HALF_W-1:0] mul_b;
	logic [PROD_W-1:0] prod;
	logic [IDX_W-1:0] diff;

	// One multiplier serves both reciprocal halves and the quotient times the size.
	always_comb begin
		quot = KEY_W'(acc_q >> SHIFT);
		mul_a = key_q;
		mul_b = RECIP_LO;
		unique case (step_q)
			STEP_LO: mul_b = RECIP_LO;
			STEP_HI: mul_b = RECIP_HI;
			default: begin
				mul_a = quot;
				mul_b = SIZE_C;
			end
		endcase
		prod = PROD_W'(mul_a) * PROD_W'(mul_b);
		diff = key_q[IDX_W-1:0] - prod[IDX_W-1:0];
	end

	// Control of the three multiply steps, which a power-of-two table size skips.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= STEP_LO;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !IS_POW2;
				done_q <= IS_POW2;
				step_q <= STEP_LO;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_REM) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Key hold, product accumulation and remainder.
	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= key;
			rem_q <= IS_POW2 ? key[IDX_W-1:0] : '0;
		end else if (busy_q) begin
			unique case (step_q)
				STEP_LO: acc_q <= ACC_W'(prod);
				STEP_HI: acc_q <= acc_q + {prod, {HALF_W{1'b0}}};
				default: rem_q <= diff;
			endcase
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign home = rem_q;

endmodule

/* hdl/linear_probe_hash_table.sv */
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tdata: key[31:0]; tuser: kind[1:0]
// m_*      out  m_tvalid/m_tready  tdata: slot[2:0], probe_distance[5:3]; tuser: status[2:0]
//
// After reset the table is swept empty, one slot per cycle, with s_tready low.
// A request first finds its home slot and then probes from it; when TABLE_SIZE is not a power
// of two, the home slot comes from reciprocal multiplication on one shared multiplier.
// The probe loop reads one slot per cycle from the single-port key memory; a hit ends it early.
// Kind 3 skips the home slot and the probe loop. A new request is taken while an earlier result
// waits in the output register; a stalled result only holds the sequencer in its final state.
`include "linear_probe_hash_table_defines.svh"

module linear_probe_hash_table #(
	parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [31:0] s_tdata, // key[31:0]
	input logic [1:0] s_tuser, // kind[1:0]
	output logic m_tvalid,
	input logic m_tready,
	output logic [7:0] m_tdata, // slot[2:0], probe_distance[5:3], zero[7:6]
	output logic [2:0] m_tuser // status[2:0]
);
	import lpht_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int CNT_W = $clog2(TABLE_SIZE + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
	localparam logic [CNT_W-1:0] SIZE_CNT = CNT_W'(TABLE_SIZE);

	state_t state_q, state_d;

	// Sequencer registers.
	logic [IDX_W-1:0] probe_q, probe_d;
	logic [CNT_W-1:0] iss_q, iss_d;
	logic pend_q, pend_d;
	logic m_tvalid_q;

	// Request and result holds.
	kind_t kind_q;
	logic [KEY_W-1:0] key_q;
	logic [IDX_W-1:0] chk_slot_q;
	logic [IDX_W-1:0] chk_dist_q;
	status_t res_status_q, res_status_d;
	logic [OUT_IDX_W-1:0] res_slot_q, res_slot_d;
	logic [OUT_IDX_W-1:0] res_dist_q, res_dist_d;
	logic res_load;
	logic [7:0] m_tdata_q;
	logic [STATUS_W-1:0] m_tuser_q;

	// Key memory.
	entry_t mem [TABLE_SIZE];
	entry_t rd_q;
	logic mem_we;
	logic mem_re;
	logic [IDX_W-1:0] mem_wa;
	entry_t mem_wd;

	logic accept;
	logic mod_start;
	mod_sts_t mod_sts;
	logic [IDX_W-1:0] home;
	logic hit;
	logic last;
	logic issue;
	logic out_load;

	assign accept = s_tvalid && s_tready;
	assign mod_start = accept && (kind_t'(s_tuser) != K_NOP);

	lpht_mod #(
		.TABLE_SIZE(TABLE_SIZE),
		.IDX_W(IDX_W)
	) u_mod (
		.clk(clk),
		.arst_n(arst_n),
		.start(mod_start),
		.key(s_tdata),
		.sts(mod_sts),
		.home(home)
	);

	// Probe compare on the entry read in the previous cycle.
	always_comb begin
		if (kind_q == K_INSERT) begin
			hit = pend_q && !rd_q.valid;
		end else begin
			hit = pend_q && rd_q.valid && (rd_q.key == key_q);
		end
		last = pend_q && (chk_dist_q == LAST_IDX);
	end

	// Next state, memory control and result selection.
	always_comb begin
		state_d = state_q;
		probe_d = probe_q;
		iss_d = iss_q;
		pend_d = 1'b0;
		issue = 1'b0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_wa = probe_q;
		mem_wd = '0;
		res_load = 1'b0;
		res_status_d = S_NOT_FOUND;
		res_slot_d = '0;
		res_dist_d = '0;
		out_load = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (probe_q == LAST_IDX) begin
					probe_d = '0;
					state_d = ST_IDLE;
				end else begin
					probe_d = probe_q + 1'b1;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (kind_t'(s_tuser) == K_NOP) begin
						res_load = 1'b1;
						state_d = ST_RESULT;
					end else begin
						state_d = ST_HOME;
					end
				end
			end
			ST_HOME: begin
				if (mod_sts.done) begin
					probe_d = home;
					iss_d = '0;
					state_d = ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (hit || last) begin
					res_load = 1'b1;
					state_d = ST_RESULT;
					if (hit) begin
						mem_we = (kind_q != K_SEARCH);
						mem_wa = chk_slot_q;
						mem_wd.valid = (kind_q == K_INSERT);
						mem_wd.key = key_q;
						res_slot_d = OUT_IDX_W'(chk_slot_q);
						res_dist_d = OUT_IDX_W'(chk_dist_q);
						unique case (kind_q)
							K_INSERT: res_status_d = S_INSERTED;
							K_DELETE: res_status_d = S_DELETED;
							default: res_status_d = S_FOUND;
						endcase
					end else begin
						res_status_d = (kind_q == K_INSERT) ? S_FULL : S_NOT_FOUND;
					end
				end else if (iss_q < SIZE_CNT) begin
					issue = 1'b1;
					mem_re = 1'b1;
					pend_d = 1'b1;
					iss_d = iss_q + 1'b1;
					probe_d = (probe_q == LAST_IDX) ? '0 : probe_q + 1'b1;
				end
			end
			ST_RESULT: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			probe_q <= '0;
			iss_q <= '0;
			pend_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			probe_q <= probe_d;
			iss_q <= iss_d;
			pend_q <= pend_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Request, probe and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind_t'(s_tuser);
			key_q <= s_tdata;
		end
		if (issue) begin
			chk_slot_q <= probe_q;
			chk_dist_q <= iss_q[IDX_W-1:0];
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_slot_q <= res_slot_d;
			res_dist_q <= res_dist_d;
		end
		if (out_load) begin
			m_tdata_q <= {2'b00, res_dist_q, res_slot_q};
			m_tuser_q <= res_status_q;
		end
	end

	// Single-port key memory with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[probe_q];
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

	`LPHT_ASSERT_NOW(a_busy_in_home, mod_sts.busy, state_q == ST_HOME, "modulo unit busy outside home phase")
	`LPHT_ASSERT_NOW(a_we_phase, mem_we, state_q == ST_CLEAR || state_q == ST_PROBE, "memory write outside clear or probe")
	`LPHT_ASSERT_NEXT(a_req_start, mod_start, state_q == ST_HOME, "request did not enter home phase")
	`LPHT_ASSERT_NOW(a_out_from_result, $rose(m_tvalid), $past(state_q) == ST_RESULT, "result shown without result phase")

endmodule
